@@ hdl/lspm_pkg.sv @@
// Shared types, constants and the arctangent table of the scan-to-map point pipeline.
`timescale 1ns / 1ps

package lspm_pkg;

    localparam int LSPM_CORDIC_STAGES = 20;
    localparam int LSPM_MAX_STAGES    = 32;

    // Beams at or above this index are rejected.
    localparam logic [16:0] LSPM_MAX_BEAMS = 17'd4096;

    // Datapath widths: rotation vector and residual angle.
    localparam int LSPM_XW = 36;
    localparam int LSPM_ZW = 32;

    // Gain compensation of the rotation, 2^-30 units.
    localparam logic [29:0] LSPM_KINV = 30'd652032874;

    // Register indexes of the configuration port.
    localparam int LSPM_CFG_IW = 3;
    localparam logic [LSPM_CFG_IW-1:0] CFG_RANGE_LOWER  = 3'd0;
    localparam logic [LSPM_CFG_IW-1:0] CFG_RANGE_UPPER  = 3'd1;
    localparam logic [LSPM_CFG_IW-1:0] CFG_START_ANGLE  = 3'd2;
    localparam logic [LSPM_CFG_IW-1:0] CFG_ANGLE_STEP   = 3'd3;
    localparam logic [LSPM_CFG_IW-1:0] CFG_POSE_X_MM    = 3'd4;
    localparam logic [LSPM_CFG_IW-1:0] CFG_POSE_Y_MM    = 3'd5;
    localparam logic [LSPM_CFG_IW-1:0] CFG_POSE_HEADING = 3'd6;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        is_finite;
        logic [11:0] beam_index;
        logic        scan_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] map_x_mm;
        logic signed [31:0] map_y_mm;
        logic               point_valid;
        logic               last_of_scan;
    } t_out_item;

    // Control that travels alongside each beat in the pipeline.
    typedef struct packed {
        logic       busy;
        logic       point_valid;
        logic       last;
        logic [1:0] quad;
    } t_side;

    typedef struct packed {
        logic signed [LSPM_XW-1:0] x;
        logic signed [LSPM_XW-1:0] y;
        logic signed [LSPM_ZW-1:0] z;
    } t_vec;

    // atan(2^-i) in 2^-32 turn units.
    function automatic logic signed [LSPM_ZW-1:0] lspm_atan(input int unsigned idx);
        logic signed [LSPM_ZW-1:0] v;
        unique case (idx)
            0:  v = 32'sh20000000;
            1:  v = 32'sh12E4051E;
            2:  v = 32'sh09FB385B;
            3:  v = 32'sh051111D4;
            4:  v = 32'sh028B0D43;
            5:  v = 32'sh0145D7E1;
            6:  v = 32'sh00A2F61E;
            7:  v = 32'sh00517C55;
            8:  v = 32'sh0028BE53;
            9:  v = 32'sh00145F2F;
            10: v = 32'sh000A2F98;
            11: v = 32'sh000517CC;
            12: v = 32'sh00028BE6;
            13: v = 32'sh000145F3;
            14: v = 32'sh0000A2FA;
            15: v = 32'sh0000517D;
            16: v = 32'sh000028BE;
            17: v = 32'sh0000145F;
            18: v = 32'sh00000A30;
            19: v = 32'sh00000518;
            20: v = 32'sh0000028C;
            21: v = 32'sh00000146;
            22: v = 32'sh000000A3;
            23: v = 32'sh00000051;
            24: v = 32'sh00000029;
            25: v = 32'sh00000014;
            26: v = 32'sh0000000A;
            27: v = 32'sh00000005;
            28: v = 32'sh00000003;
            29: v = 32'sh00000001;
            30: v = 32'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/laser_scan_to_map_points_top.sv @@
// Top level: laser range samples in, map-frame points out.
//
// Input channel i_in_valid / o_in_ready carries one range sample a beat;
// output channel o_out_valid / i_out_ready returns exactly one result a beat
// per sample, in order, with point_valid low and zero coordinates when the
// sample fails the finite, range or beam index checks.
// The configuration write channel (i_cfg_valid / o_cfg_ready, register index
// and data) is always ready and should only be used while the block is idle.
// Throughput is one sample per cycle while the receiver does not stall. The
// checks and the beam angle product are registered at the accepting edge
// (stage F1), then each CORDIC micro-rotation stage is registered, then the
// split gain multiply (G1) and the recombine and rounding (G2), and last
// quadrant, pose offset and saturation go into the output register.
// When the receiver stalls, a skid register catches the beat in flight and
// the whole pipeline then holds; o_in_ready is taken straight from a flop.
// Reset (synchronous, active low) empties the pipeline and returns the
// registers to their defaults: full range window, zero angles and zero pose.
`timescale 1ns / 1ps

module laser_scan_to_map_points_top import lspm_pkg::*; #(
    parameter int CORDIC_STAGES = LSPM_CORDIC_STAGES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LSPM_CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    localparam int NST = (CORDIC_STAGES > LSPM_MAX_STAGES) ? LSPM_MAX_STAGES : CORDIC_STAGES;
    localparam logic signed [30:0] KINV_S = $signed({1'b0, LSPM_KINV});
    localparam logic signed [69:0] ROUND_HALF = 70'sh2000_0000_0000;

    // Configuration registers.
    logic [15:0] r_range_lower;
    logic [15:0] r_range_upper;
    logic [23:0] r_start_angle;
    logic [23:0] r_angle_step;
    logic [31:0] r_pose_x_mm;
    logic [31:0] r_pose_y_mm;
    logic [23:0] r_pose_heading;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_lower  <= 16'd0;
            r_range_upper  <= 16'hFFFF;
            r_start_angle  <= '0;
            r_angle_step   <= '0;
            r_pose_x_mm    <= '0;
            r_pose_y_mm    <= '0;
            r_pose_heading <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOWER:  r_range_lower  <= i_cfg_data[15:0];
                CFG_RANGE_UPPER:  r_range_upper  <= i_cfg_data[15:0];
                CFG_START_ANGLE:  r_start_angle  <= i_cfg_data[23:0];
                CFG_ANGLE_STEP:   r_angle_step   <= i_cfg_data[23:0];
                CFG_POSE_X_MM:    r_pose_x_mm    <= i_cfg_data;
                CFG_POSE_Y_MM:    r_pose_y_mm    <= i_cfg_data;
                CFG_POSE_HEADING: r_pose_heading <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Output register and skid register.
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // Stage F1: checks and beam angle product.
    logic        w_check;
    logic [35:0] w_prod_full;
    logic        r_f1_busy;
    logic        r_f1_valid;
    logic        r_f1_last;
    logic [15:0] r_f1_range;
    logic [23:0] r_f1_prod;

    assign w_check = i_in_item.is_finite
        && (i_in_item.range_mm > r_range_lower)
        && (i_in_item.range_mm < r_range_upper)
        && ({5'b0, i_in_item.beam_index} < LSPM_MAX_BEAMS);
    assign w_prod_full = r_angle_step * i_in_item.beam_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_busy <= 1'b0;
        end else if (w_en) begin
            r_f1_busy <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_valid <= w_check;
            r_f1_last  <= i_in_item.scan_end;
            r_f1_range <= i_in_item.range_mm;
            r_f1_prod  <= w_prod_full[23:0];
        end
    end

    // Beam angle wraps modulo one turn; the top two bits pick the quadrant.
    logic [23:0] w_ang;
    t_vec        w_cin_vec;
    t_side       w_cin_side;
    t_vec        w_cout_vec;
    t_side       w_cout_side;

    assign w_ang            = r_start_angle + r_f1_prod + r_pose_heading;
    assign w_cin_vec.x      = $signed({4'b0, r_f1_range, 16'b0});
    assign w_cin_vec.y      = '0;
    assign w_cin_vec.z      = $signed({2'b0, w_ang[21:0], 8'b0});
    assign w_cin_side.busy        = r_f1_busy;
    assign w_cin_side.point_valid = r_f1_valid;
    assign w_cin_side.last        = r_f1_last;
    assign w_cin_side.quad        = w_ang[23:22];

    lspm_cordic #(
        .STAGES (NST)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vec   (w_cin_vec),
        .i_side  (w_cin_side),
        .o_vec   (w_cout_vec),
        .o_side  (w_cout_side)
    );

    // Stage G1: gain multiply split into high and low partial products.
    logic signed [LSPM_XW-1:0] w_cx;
    logic signed [LSPM_XW-1:0] w_cy;
    logic signed [17:0]        w_xh;
    logic signed [17:0]        w_yh;
    logic [17:0]               w_xl;
    logic [17:0]               w_yl;
    logic signed [48:0]        n_phx;
    logic signed [48:0]        n_phy;
    logic [47:0]               n_plx;
    logic [47:0]               n_ply;
    logic signed [48:0]        r_phx;
    logic signed [48:0]        r_phy;
    logic [47:0]               r_plx;
    logic [47:0]               r_ply;
    t_side                     r_g1_side;

    assign w_cx  = w_cout_vec.x;
    assign w_cy  = w_cout_vec.y;
    assign w_xh  = w_cx[35:18];
    assign w_yh  = w_cy[35:18];
    assign w_xl  = w_cx[17:0];
    assign w_yl  = w_cy[17:0];
    assign n_phx = w_xh * KINV_S;
    assign n_phy = w_yh * KINV_S;
    assign n_plx = w_xl * LSPM_KINV;
    assign n_ply = w_yl * LSPM_KINV;

    // Stage G2: recombine, round to millimetres.
    logic signed [69:0] w_sumx;
    logic signed [69:0] w_sumy;
    logic signed [23:0] r_rx;
    logic signed [23:0] r_ry;
    t_side              r_g2_side;

    assign w_sumx = (70'(r_phx) <<< 18) + $signed({22'b0, r_plx}) + ROUND_HALF;
    assign w_sumy = (70'(r_phy) <<< 18) + $signed({22'b0, r_ply}) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_side <= '0;
            r_g2_side <= '0;
        end else if (w_en) begin
            r_g1_side <= w_cout_side;
            r_g2_side <= r_g1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phx <= n_phx;
            r_phy <= n_phy;
            r_plx <= n_plx;
            r_ply <= n_ply;
            r_rx  <= w_sumx[69:46];
            r_ry  <= w_sumy[69:46];
        end
    end

    // Final stage: quadrant rotation, pose offset and saturation.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] s;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            s = v[31:0];
        end else if (v[33]) begin
            s = 32'sh8000_0000;
        end else begin
            s = 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

    logic signed [33:0] w_rx;
    logic signed [33:0] w_ry;
    logic signed [33:0] w_ox;
    logic signed [33:0] w_oy;
    logic signed [33:0] w_mx;
    logic signed [33:0] w_my;
    t_out_item          n_out;

    assign w_rx = 34'(r_rx);
    assign w_ry = 34'(r_ry);

    always_comb begin
        unique case (r_g2_side.quad)
            2'd0: begin
                w_ox = w_rx;
                w_oy = w_ry;
            end
            2'd1: begin
                w_ox = -w_ry;
                w_oy = w_rx;
            end
            2'd2: begin
                w_ox = -w_rx;
                w_oy = -w_ry;
            end
            2'd3: begin
                w_ox = w_ry;
                w_oy = -w_rx;
            end
        endcase
    end

    assign w_mx = w_ox + 34'($signed(r_pose_x_mm));
    assign w_my = w_oy + 34'($signed(r_pose_y_mm));

    assign n_out.map_x_mm     = r_g2_side.point_valid ? sat32(w_mx) : '0;
    assign n_out.map_y_mm     = r_g2_side.point_valid ? sat32(w_my) : '0;
    assign n_out.point_valid  = r_g2_side.point_valid;
    assign n_out.last_of_scan = r_g2_side.last;

    // The skid register takes the beat arriving while the output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_g2_side.busy;
            end
        end else if (w_en && r_g2_side.busy) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_out;
        end else if (w_en && r_g2_side.busy) begin
            r_skid <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without an output stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.point_valid)
            |-> (o_out_item.map_x_mm == 0 && o_out_item.map_y_mm == 0))
        else $error("rejected sample carries non-zero coordinates");
`endif

endmodule

@@ hdl/lspm_cordic.sv @@
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps

module lspm_cordic import lspm_pkg::*; #(
    parameter int STAGES = LSPM_CORDIC_STAGES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_vec  i_vec,
    input  t_side i_side,
    output t_vec  o_vec,
    output t_side o_side
);

    logic signed [LSPM_XW-1:0] r_x [STAGES];
    logic signed [LSPM_XW-1:0] r_y [STAGES];
    logic signed [LSPM_ZW-1:0] r_z [STAGES];
    t_side                     r_side [STAGES];

    logic signed [LSPM_XW-1:0] n_x [STAGES];
    logic signed [LSPM_XW-1:0] n_y [STAGES];
    logic signed [LSPM_ZW-1:0] n_z [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [LSPM_XW-1:0] w_x;
        logic signed [LSPM_XW-1:0] w_y;
        logic signed [LSPM_ZW-1:0] w_z;
        t_side                     w_side;

        if (i == 0) begin : g_first
            assign w_x    = i_vec.x;
            assign w_y    = i_vec.y;
            assign w_z    = i_vec.z;
            assign w_side = i_side;
        end else begin : g_next
            assign w_x    = r_x[i-1];
            assign w_y    = r_y[i-1];
            assign w_z    = r_z[i-1];
            assign w_side = r_side[i-1];
        end

        // A residual of zero or more rotates in the positive sense.
        assign n_x[i] = (w_z >= 0) ? w_x - (w_y >>> i) : w_x + (w_y >>> i);
        assign n_y[i] = (w_z >= 0) ? w_y + (w_x >>> i) : w_y - (w_x >>> i);
        assign n_z[i] = (w_z >= 0) ? w_z - lspm_atan(i) : w_z + lspm_atan(i);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[i] <= '0;
            end else if (i_en) begin
                r_side[i] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_vec.x = r_x[STAGES-1];
    assign o_vec.y = r_y[STAGES-1];
    assign o_vec.z = r_z[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
